/* rtl/bpae_pkg.sv */
// Shared types and constants for the bright-pixel auto exposure core.
// No dependencies; every other file in rtl/ imports this package.
package bpae_pkg;

    localparam int PIX_W      = 8;
    localparam int CNT_W      = 23;
    localparam int BP_W       = 14;
    localparam int EXPO_W     = 7;
    localparam int PROD_W     = CNT_W + BP_W;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CNT_W-1:0]  MAX_PIXELS  = CNT_W'(4194304);
    localparam logic [BP_W-1:0]   BP_SCALE    = BP_W'(10000);
    localparam logic [EXPO_W-1:0] EXPO_MAX    = EXPO_W'(100);
    localparam logic [EXPO_W-1:0] EXPO_RESET  = EXPO_W'(10);

    localparam logic [PIX_W-1:0] BRIGHT_LEVEL_RESET = PIX_W'(200);
    localparam logic [BP_W-1:0]  LOW_FRAC_RESET     = BP_W'(5);
    localparam logic [BP_W-1:0]  HIGH_FRAC_RESET    = BP_W'(500);

    typedef enum logic [1:0] {
        REG_BRIGHT_LEVEL = 2'd0,
        REG_LOW_FRAC     = 2'd1,
        REG_HIGH_FRAC    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [EXPO_W-1:0] exposure_level;
        logic              lowered;
        logic              raised;
        logic [CNT_W-1:0]  bright_pixels;
    } t_result;

endpackage

/* rtl/bpae_if.sv */
// Stream channels of the auto exposure core: pixel in, exposure result out.
// Depends on bpae_pkg for field widths.
interface bpae_pix_if;
    import bpae_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             frame_end;

    modport source (output valid, blue, green, red, frame_end, input ready);
    modport sink   (input valid, blue, green, red, frame_end, output ready);
endinterface

interface bpae_res_if;
    import bpae_pkg::*;
    logic              valid;
    logic              ready;
    logic [EXPO_W-1:0] exposure_level;
    logic              lowered;
    logic              raised;
    logic [CNT_W-1:0]  bright_pixels;

    modport source (output valid, exposure_level, lowered, raised, bright_pixels,
                    input ready);
    modport sink   (input valid, exposure_level, lowered, raised, bright_pixels,
                    output ready);
endinterface

/* rtl/bright_pixel_auto_exposure_core.sv */
// Bright-pixel auto exposure core: frame statistics and exposure stepping.
// Depends on bpae_pkg and the channel interfaces in bpae_if.sv.
// Throughput: one pixel per cycle while no frame end waits for room in the snapshot stage.
// Pixels without frame_end retire in the input stage. A frame-end pixel passes the input
// register, count snapshot and products; compare and exposure step load the output register.
// Reset (synchronous, active low) clears the counters and restores registers and exposure 10.
module bright_pixel_auto_exposure_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bpae_pix_if.sink                          i_pix,
    bpae_res_if.source                        o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bpae_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bpae_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bpae_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import bpae_pkg::*;

    // Configuration registers
    logic [PIX_W-1:0] r_bright_level;
    logic [BP_W-1:0]  r_low_frac;
    logic [BP_W-1:0]  r_high_frac;
    logic             apb_wr;
    t_reg_idx         reg_idx;

    // Stage A: input register and running counters
    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_blue;
    logic [PIX_W-1:0] r_a_green;
    logic [PIX_W-1:0] r_a_red;
    logic             r_a_frame_end;
    logic [CNT_W-1:0] r_pix_cnt;
    logic [CNT_W-1:0] r_bright_cnt;
    logic [PIX_W-1:0] pix_max;
    logic             is_bright;
    logic [CNT_W-1:0] n_pix_cnt;
    logic [CNT_W-1:0] n_bright_cnt;
    logic             a_retire;

    // Stage B: frame snapshot
    logic             r_b_valid;
    logic [CNT_W-1:0] r_b_pix;
    logic [CNT_W-1:0] r_b_bright;
    logic             ready_b;

    // Stage C: products
    logic              r_c_valid;
    logic [PROD_W-1:0] r_c_scaled;
    logic [PROD_W-1:0] r_c_hi;
    logic [PROD_W-1:0] r_c_lo;
    logic [CNT_W-1:0]  r_c_bright;
    logic              ready_c;

    // Output stage
    logic              r_o_valid;
    t_result           r_o;
    logic              ready_o;
    logic [EXPO_W-1:0] r_expo;
    logic [EXPO_W-1:0] n_expo;
    logic [EXPO_W-1:0] expo_dn;
    logic              lower;
    logic              raise;
    logic              c_retire;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx)
            REG_BRIGHT_LEVEL: prdata = APB_DATA_W'(r_bright_level);
            REG_LOW_FRAC:     prdata = APB_DATA_W'(r_low_frac);
            REG_HIGH_FRAC:    prdata = APB_DATA_W'(r_high_frac);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_level <= BRIGHT_LEVEL_RESET;
            r_low_frac     <= LOW_FRAC_RESET;
            r_high_frac    <= HIGH_FRAC_RESET;
        end else if (apb_wr) begin
            unique case (reg_idx)
                REG_BRIGHT_LEVEL: r_bright_level <= pwdata[PIX_W-1:0];
                REG_LOW_FRAC:     r_low_frac     <= pwdata[BP_W-1:0];
                REG_HIGH_FRAC:    r_high_frac    <= pwdata[BP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- backpressure chain ----------------
    assign ready_o  = !r_o_valid || o_res.ready;
    assign ready_c  = !r_c_valid || ready_o;
    assign ready_b  = !r_b_valid || ready_c;
    // a plain pixel always retires; a frame end waits for room in the snapshot stage
    assign a_retire = r_a_valid && (!r_a_frame_end || ready_b);
    assign i_pix.ready = !r_a_valid || a_retire;
    assign c_retire = r_c_valid && ready_o;

    // ---------------- stage A ----------------
    always_comb begin
        pix_max = r_a_blue;
        if (r_a_green > pix_max) pix_max = r_a_green;
        if (r_a_red > pix_max) pix_max = r_a_red;
        is_bright = pix_max > r_bright_level;
        n_pix_cnt = (r_pix_cnt < MAX_PIXELS) ? r_pix_cnt + 1'b1 : MAX_PIXELS;
        n_bright_cnt = r_bright_cnt;
        if (is_bright && r_bright_cnt < MAX_PIXELS) n_bright_cnt = r_bright_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_pix_cnt    <= '0;
            r_bright_cnt <= '0;
        end else begin
            if (i_pix.valid && i_pix.ready) r_a_valid <= 1'b1;
            else if (a_retire)              r_a_valid <= 1'b0;
            if (a_retire) begin
                // clear on the closing pixel, its counts move to the snapshot
                r_pix_cnt    <= r_a_frame_end ? '0 : n_pix_cnt;
                r_bright_cnt <= r_a_frame_end ? '0 : n_bright_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_a_blue      <= i_pix.blue;
            r_a_green     <= i_pix.green;
            r_a_red       <= i_pix.red;
            r_a_frame_end <= i_pix.frame_end;
        end
    end

    // ---------------- stage B ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= a_retire && r_a_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && a_retire && r_a_frame_end) begin
            r_b_pix    <= n_pix_cnt;
            r_b_bright <= n_bright_cnt;
        end
    end

    // ---------------- stage C: cross products ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (ready_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && r_b_valid) begin
            r_c_scaled <= PROD_W'(r_b_bright) * PROD_W'(BP_SCALE);
            r_c_hi     <= PROD_W'(r_b_pix) * PROD_W'(r_high_frac);
            r_c_lo     <= PROD_W'(r_b_pix) * PROD_W'(r_low_frac);
            r_c_bright <= r_b_bright;
        end
    end

    // ---------------- compare and exposure step ----------------
    always_comb begin
        lower   = r_c_scaled > r_c_hi;
        raise   = r_c_scaled < r_c_lo;
        expo_dn = r_expo;
        if (lower) expo_dn = (r_expo > EXPO_W'(1)) ? r_expo - 1'b1 : '0;
        n_expo = expo_dn;
        if (raise) n_expo = (expo_dn < EXPO_MAX) ? expo_dn + 1'b1 : EXPO_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_expo    <= EXPO_RESET;
        end else begin
            if (c_retire)          r_o_valid <= 1'b1;
            else if (o_res.ready)  r_o_valid <= 1'b0;
            if (c_retire)          r_expo    <= n_expo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_retire) begin
            r_o.exposure_level <= n_expo;
            r_o.lowered        <= lower;
            r_o.raised         <= raise;
            r_o.bright_pixels  <= r_c_bright;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.exposure_level = r_o.exposure_level;
    assign o_res.lowered        = r_o.lowered;
    assign o_res.raised         = r_o.raised;
    assign o_res.bright_pixels  = r_o.bright_pixels;

    // ---------------- assertions ----------------
    a_expo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expo <= EXPO_MAX)
        else $error("exposure out of range");

    a_bright_le_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bright_cnt <= r_pix_cnt)
        else $error("bright count exceeds pixel count");

    a_pix_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_cnt <= MAX_PIXELS)
        else $error("pixel count beyond saturation");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_a_valid && r_a_frame_end && r_b_valid))
        else $error("input stalled without a pending frame end");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_retire |=> (r_o_valid && r_o.exposure_level == r_expo))
        else $error("result not loaded with updated exposure");

endmodule

/* verif/tb_top.sv */
// Self-checking bench for the bright-pixel auto exposure core: pixel stream in, one exposure
// report per frame out, APB register writes between traffic phases.
// Depends on bpae_pkg, the channel interfaces in rtl/bpae_if.sv and the core itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpae_pkg::*;

    // idle margin after the last expected report, before a register write
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] REG_SPARE_IDX = 2'd3;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [1:0]       idx;
        logic [31:0]      value;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             frame_end;
        bit               typed;
        t_result          want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bpae_pix_if pix_ch();
    bpae_res_if res_ch();

    bright_pixel_auto_exposure_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of registers and frame statistics
    logic [PIX_W-1:0]  cfg_level;
    logic [BP_W-1:0]   cfg_low;
    logic [BP_W-1:0]   cfg_high;
    logic [CNT_W-1:0]  frame_pixels;
    logic [CNT_W-1:0]  frame_bright;
    logic [EXPO_W-1:0] exposure_now;

    t_result   report_q[$];
    t_stim_row directed_rows[$];
    t_result   due;

    int sender_idle_pct;
    int sink_stall_pct;
    int hold_left;
    int mismatches;
    int pixels_sent;
    int reports_checked;
    int lowered_seen;
    int raised_seen;
    int floor_hits;
    int ceiling_hits;
    int reg_writes;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Fold one pixel into the frame statistics; on frame end, step the exposure and
    // return 1 with the report the core must produce.
    function automatic bit fold_pixel(input logic [PIX_W-1:0] b, g, r, input logic last,
                                      output t_result rep);
        logic [PIX_W-1:0] peak;
        logic [63:0]      scaled;
        logic [63:0]      low_mark;
        logic [63:0]      high_mark;
        bit               drop;
        bit               lift;
        peak = b;
        if (g > peak) peak = g;
        if (r > peak) peak = r;
        if (frame_pixels < MAX_PIXELS) frame_pixels++;
        if (peak > cfg_level && frame_bright < MAX_PIXELS) frame_bright++;
        rep = '0;
        if (!last) return 1'b0;
        scaled    = 64'(frame_bright) * 64'(BP_SCALE);
        high_mark = 64'(cfg_high) * 64'(frame_pixels);
        low_mark  = 64'(cfg_low) * 64'(frame_pixels);
        drop = scaled > high_mark;
        lift = scaled < low_mark;
        // step down first, then up: both can apply when low sits above high
        if (drop) exposure_now = (exposure_now > 1) ? exposure_now - 1'b1 : '0;
        if (lift && exposure_now < EXPO_MAX) exposure_now++;
        rep.exposure_level = exposure_now;
        rep.lowered        = drop;
        rep.raised         = lift;
        rep.bright_pixels  = frame_bright;
        frame_pixels = '0;
        frame_bright = '0;
        return 1'b1;
    endfunction

    task automatic offer_pixel(input logic [PIX_W-1:0] b, g, r, input logic last,
                               input bit typed, input t_result want);
        t_result rep;
        while ($urandom_range(99) < sender_idle_pct) begin
            pix_ch.valid <= 1'b0;
            {pix_ch.blue, pix_ch.green, pix_ch.red} <= 24'($urandom);
            pix_ch.frame_end <= 1'($urandom);
            @(posedge i_clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.blue      <= b;
        pix_ch.green     <= g;
        pix_ch.red       <= r;
        pix_ch.frame_end <= last;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        pixels_sent++;
        if (fold_pixel(b, g, r, last, rep)) report_q.push_back(typed ? want : rep);
    endtask

    task automatic drain_block();
        pix_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic [1:0] idx, input bit is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] readback;
        logic [31:0] stored;
        drain_block();
        apb_access(idx, 1'b1, data, readback);
        reg_writes++;
        stored = '0;
        case (idx)
            REG_BRIGHT_LEVEL: begin
                cfg_level = data[PIX_W-1:0];
                stored = 32'(cfg_level);
            end
            REG_LOW_FRAC: begin
                cfg_low = data[BP_W-1:0];
                stored = 32'(cfg_low);
            end
            REG_HIGH_FRAC: begin
                cfg_high = data[BP_W-1:0];
                stored = 32'(cfg_high);
            end
            default: ;  // nothing behind this address; the write must land nowhere
        endcase
        if (idx != REG_SPARE_IDX) begin
            apb_access(idx, 1'b0, '0, readback);
            if (readback !== stored) report_mismatch("register readback", readback, stored);
        end
    endtask

    task automatic run_phase(input logic [PIX_W-1:0] level, input logic [BP_W-1:0] low, high,
                             input int idle_pct, stall_pct, n_items, max_frame, hold);
        int               left;
        int               frame_len;
        int               bright_pct;
        logic [PIX_W-1:0] ch [3];
        set_register(REG_BRIGHT_LEVEL, {24'($urandom), level});
        set_register(REG_LOW_FRAC, {18'($urandom), low});
        set_register(REG_HIGH_FRAC, {18'($urandom), high});
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        hold_left       = hold;
        left = n_items;
        while (left > 0) begin
            frame_len  = $urandom_range(max_frame, 1);
            bright_pct = $urandom_range(100);
            for (int k = frame_len; k > 0 && left > 0; k--, left--) begin
                if ($urandom_range(7) == 0) begin
                    {ch[0], ch[1], ch[2]} = 24'($urandom);
                end else begin
                    foreach (ch[j]) ch[j] = PIX_W'($urandom_range(level));
                    // lift one channel over the level to make the pixel bright
                    if ($urandom_range(99) < bright_pct && level != '1)
                        ch[$urandom_range(2)] = PIX_W'($urandom_range(255, int'(level) + 1));
                end
                offer_pixel(ch[0], ch[1], ch[2], k == 1, 1'b0, '0);
            end
        end
    endtask

    function automatic t_stim_row pixel_row(input logic [PIX_W-1:0] b, g, r,
                                            input logic last);
        t_stim_row row;
        row = '{kind: ROW_PIXEL, idx: '0, value: '0, blue: b, green: g, red: r,
                frame_end: last, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_stim_row checked_row(input logic [PIX_W-1:0] b, g, r,
                                              input int expo, input bit dn, up,
                                              input int count);
        t_stim_row row;
        row = pixel_row(b, g, r, 1'b1);
        row.typed = 1'b1;
        row.want.exposure_level = EXPO_W'(expo);
        row.want.lowered        = dn;
        row.want.raised         = up;
        row.want.bright_pixels  = CNT_W'(count);
        return row;
    endfunction

    function automatic t_stim_row write_row(input logic [1:0] idx, input logic [31:0] value);
        t_stim_row row;
        row = pixel_row('0, '0, '0, 1'b0);
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.value = value;
        return row;
    endfunction

    // receiver: random stalls, plus a long hold-off when one is requested
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (report_q.size() == 0) begin
                report_mismatch("report with none pending", res_ch.exposure_level, 0);
            end else begin
                due = report_q.pop_front();
                reports_checked++;
                if (due.lowered) lowered_seen++;
                if (due.raised) raised_seen++;
                if (due.lowered && due.exposure_level == 0) floor_hits++;
                if (due.raised && due.exposure_level == EXPO_MAX) ceiling_hits++;
                if (res_ch.exposure_level !== due.exposure_level)
                    report_mismatch("exposure_level", res_ch.exposure_level, due.exposure_level);
                if (res_ch.lowered !== due.lowered)
                    report_mismatch("lowered", res_ch.lowered, due.lowered);
                if (res_ch.raised !== due.raised)
                    report_mismatch("raised", res_ch.raised, due.raised);
                if (res_ch.bright_pixels !== due.bright_pixels)
                    report_mismatch("bright_pixels", res_ch.bright_pixels, due.bright_pixels);
            end
        end
    end

    initial begin
        t_stim_row row;
        pix_ch.valid     <= 1'b0;
        pix_ch.blue      <= '0;
        pix_ch.green     <= '0;
        pix_ch.red       <= '0;
        pix_ch.frame_end <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        cfg_level    = BRIGHT_LEVEL_RESET;
        cfg_low      = LOW_FRAC_RESET;
        cfg_high     = HIGH_FRAC_RESET;
        frame_pixels = '0;
        frame_bright = '0;
        exposure_now = EXPO_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: an all-dark pixel raises, an all-bright one lowers
        directed_rows.push_back(checked_row(8'd0, 8'd0, 8'd0, 11, 1'b0, 1'b1, 0));
        directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 10, 1'b1, 1'b0, 1));
        // level boundary on each channel: one above counts, the level itself does not
        directed_rows.push_back(pixel_row(8'd201, 8'd0, 8'd0, 1'b0));
        directed_rows.push_back(pixel_row(8'd0, 8'd201, 8'd0, 1'b0));
        directed_rows.push_back(pixel_row(8'd0, 8'd0, 8'd201, 1'b0));
        directed_rows.push_back(checked_row(8'd200, 8'd200, 8'd200, 9, 1'b1, 1'b0, 3));
        // fraction exactly on the high threshold does not lower
        directed_rows.push_back(write_row(REG_HIGH_FRAC, 32'd5000));
        directed_rows.push_back(pixel_row(8'd255, 8'd0, 8'd0, 1'b0));
        directed_rows.push_back(checked_row(8'd0, 8'd0, 8'd0, 9, 1'b0, 1'b0, 1));
        // low above high: step down and up in the same frame
        directed_rows.push_back(write_row(REG_LOW_FRAC, 32'h3FFF));
        directed_rows.push_back(write_row(REG_HIGH_FRAC, 32'd0));
        directed_rows.push_back(checked_row(8'd0, 8'd0, 8'd255, 9, 1'b1, 1'b1, 1));
        // walk the exposure down to zero and hold it there
        directed_rows.push_back(write_row(REG_LOW_FRAC, 32'd0));
        for (int e = 8; e >= 0; e--)
            directed_rows.push_back(checked_row(8'd0, 8'd255, 8'd0, e, 1'b1, 1'b0, 1));
        directed_rows.push_back(checked_row(8'd0, 8'd255, 8'd0, 0, 1'b1, 1'b0, 1));
        // top level: nothing is bright
        directed_rows.push_back(write_row(REG_BRIGHT_LEVEL, 32'd255));
        directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 0, 1'b0, 1'b0, 0));
        // unused address must leave every register alone
        directed_rows.push_back(write_row(REG_SPARE_IDX, 32'd0));
        directed_rows.push_back(checked_row(8'd255, 8'd255, 8'd255, 0, 1'b0, 1'b0, 0));

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.kind == ROW_WRITE) begin
                set_register(row.idx, row.value);
            end else begin
                offer_pixel(row.blue, row.green, row.red, row.frame_end, row.typed, row.want);
            end
        end

        run_phase(8'd200, 14'd5, 14'd500, 0, 0, 250, 40, 0);
        run_phase(8'd0, 14'd0, 14'd0, 73, 0, 200, 6, 0);
        run_phase(8'd255, 14'h3FFF, 14'h3FFF, 0, 73, 300, 2, 0);
        run_phase(PIX_W'($urandom), BP_W'($urandom_range(10000)),
                  BP_W'($urandom_range(10000)), 35, 35, 300, 30, 0);
        // long receiver hold-off with the sender flat out: fill the core and stall its input
        run_phase(8'd128, 14'd2000, 14'd3000, 0, 0, 150, 2, 300);
        run_phase(PIX_W'($urandom), BP_W'($urandom_range(16383, 5000)),
                  BP_W'($urandom_range(4999)), 35, 35, 200, 10, 0);
        run_phase(PIX_W'($urandom), BP_W'($urandom), BP_W'($urandom), 73, 73, 150, 20, 0);
        drain_block();

        $display("Covered %0d pixels, %0d frame reports and %0d register writes",
                 pixels_sent, reports_checked, reg_writes);
        $display("Exposure lowered %0d, raised %0d; held at floor %0d, at ceiling %0d",
                 lowered_seen, raised_seen, floor_hits, ceiling_hits);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/bpae_pkg.sv
rtl/bpae_if.sv
rtl/bright_pixel_auto_exposure_core.sv
verif/tb_top.sv
